FILE: src/nsr_pkg.sv
package nsr_pkg;

  localparam int ROM_SITES = 6;
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;
  localparam logic [30:0] U1_FLOOR = 31'd2048;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [14:0] NOISE_GAIN_Q16 = 15'd19661;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [37:0] SQ_TOP_BIT = 38'h10_0000_0000;

  localparam logic signed [11:0] TEMP_MIN = -12'sd500;
  localparam logic signed [11:0] TEMP_MAX = 12'sd800;
  localparam logic signed [11:0] HUM_MAX = 12'sd1000;

  localparam logic signed [11:0] BAND_LIM0 = 12'sd100;
  localparam logic signed [11:0] BAND_LIM1 = 12'sd180;
  localparam logic signed [11:0] BAND_LIM2 = 12'sd240;
  localparam logic signed [11:0] BAND_LIM3 = 12'sd280;
  localparam logic signed [11:0] BAND_LIM4 = 12'sd350;

  typedef logic [9:0] tenths_t [ROM_SITES];
  typedef logic [6:0] spread_t [ROM_SITES];

  localparam tenths_t NOMINAL_TEMP = '{10'd250, 10'd245, 10'd265, 10'd260, 10'd252, 10'd280};
  localparam tenths_t BASE_HUM = '{10'd600, 10'd580, 10'd550, 10'd700, 10'd570, 10'd500};
  localparam spread_t SPREAD_TEMP = '{7'd10, 7'd8, 7'd15, 7'd10, 7'd5, 7'd20};
  localparam spread_t SPREAD_HUM = '{7'd30, 7'd25, 7'd50, 7'd40, 7'd20, 7'd80};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW1,
    S_DRAW2,
    S_NORM,
    S_SQINIT,
    S_SQRT,
    S_MULZ,
    S_MULN,
    S_MULOFF,
    S_OUT
  } nsr_state_t;

  typedef struct packed {
    logic load_site;
    logic draw1;
    logic draw2;
    logic norm_step;
    logic sq_init;
    logic sq_step;
    logic mul_z;
    logic mul_n;
    logic mul_off;
    logic load_out;
  } nsr_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic sq_done;
    logic out_free;
  } nsr_status_t;

endpackage

FILE: src/nsr_if.sv
interface nsr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] site_index;
  modport source(output valid, output site_index, input ready);
  modport sink(input valid, input site_index, output ready);
endinterface

interface nsr_out_if;
  logic              valid;
  logic              ready;
  logic signed [10:0] temperature_tenths;
  logic [9:0]        humidity_tenths;
  logic [2:0]        comfort_band;
  logic [2:0]        site_used;
  modport source(output valid, output temperature_tenths, output humidity_tenths,
                 output comfort_band, output site_used, input ready);
  modport sink(input valid, input temperature_tenths, input humidity_tenths,
               input comfort_band, input site_used, output ready);
endinterface

interface nsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] noise_seed;
  modport source(output valid, output noise_seed, input ready);
  modport sink(input valid, input noise_seed, output ready);
endinterface

FILE: src/nsr_ctrl.sv
module nsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nsr_pkg::nsr_status_t status,
  output nsr_pkg::nsr_cmd_t   cmd
);
  import nsr_pkg::*;

  nsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_site = 1'b1;
          state_nxt = S_DRAW1;
        end
      end
      S_DRAW1: begin
        cmd.draw1 = 1'b1;
        state_nxt = S_DRAW2;
      end
      S_DRAW2: begin
        cmd.draw2 = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (status.norm_done) begin
          state_nxt = S_SQINIT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQINIT: begin
        cmd.sq_init = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (status.sq_done) begin
          state_nxt = S_MULZ;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_MULZ: begin
        cmd.mul_z = 1'b1;
        state_nxt = S_MULN;
      end
      S_MULN: begin
        cmd.mul_n = 1'b1;
        state_nxt = S_MULOFF;
      end
      S_MULOFF: begin
        cmd.mul_off = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_draws: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DRAW1))
    else $error("accepted request did not start the generator");

  a_sqrt_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && status.sq_done) |=> (state_r == S_MULZ))
    else $error("root iteration did not hand over to the multiplier");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !status.out_free) |=> (state_r == S_OUT))
    else $error("result dropped while output register busy");

endmodule

FILE: src/nsr_datapath.sv
module nsr_datapath #(
  parameter int SITES = 6,
  parameter int LOG_TABLE_BITS = 10,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_site_index,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_seed,
  input  nsr_pkg::nsr_cmd_t    cmd,
  output nsr_pkg::nsr_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [10:0]   out_temperature_tenths,
  output logic [9:0]           out_humidity_tenths,
  output logic [2:0]           out_comfort_band,
  output logic [2:0]           out_site_used
);
  import nsr_pkg::*;

  localparam int LOG_N = 1 << LOG_TABLE_BITS;
  localparam int COS_N = 1 << COS_TABLE_BITS;

  typedef logic [15:0] log_tab_t [LOG_N];
  typedef logic [16:0] cos_tab_t [COS_N + 1];

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t tab;
    logic [63:0] n2, t, t2, pw, sum, kk;
    n2 = 64'(2 * LOG_N);
    for (int k = 0; k < LOG_N; k++) begin
      kk = 64'(k);
      t = udiv(kk << 32, n2 + kk);
      t2 = (t * t) >> 32;
      pw = t;
      sum = '0;
      for (int i = 0; i < 14; i++) begin
        sum = sum + udiv(pw, 64'(2 * i + 1));
        pw = (pw * t2) >> 32;
      end
      tab[k] = 16'((2 * sum + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  function automatic cos_tab_t build_cos();
    cos_tab_t tab;
    logic [63:0] x, x2, term;
    logic signed [63:0] sum;
    for (int k = 0; k <= COS_N; k++) begin
      x = (64'd421657428 * 64'(k)) >> COS_TABLE_BITS;
      x2 = (x * x) >> 28;
      term = 64'd1 << 28;
      sum = '0;
      for (int i = 0; i < 14; i++) begin
        if (i % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
        term = udiv((term * x2) >> 28, 64'((2 * i + 1) * (2 * i + 2)));
      end
      if (sum < 0) begin
        sum = '0;
      end
      tab[k] = 17'(($unsigned(sum) + 64'd2048) >> 12);
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam cos_tab_t COS_TAB = build_cos();

  logic [31:0] rng_r;
  logic [2:0]  site_r;
  logic [30:0] u1_r, u2_r;
  logic [4:0]  e_r;
  logic [15:0] log_q_r;
  logic [16:0] cos_q_r;
  logic [37:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [19:0] z_r;
  logic [16:0] n_r;
  logic [6:0]  toff_r, hoff_r;
  logic        neg_r;
  logic        out_valid_r;
  logic signed [10:0] temp_r;
  logic [9:0]  hum_r;
  logic [2:0]  band_r, used_r;

  logic [31:0] rng_nxt;
  logic [2:0]  site_nxt;
  logic [COS_TABLE_BITS-1:0] cos_k;
  logic [COS_TABLE_BITS:0]   cos_idx;
  logic [20:0] lq;
  logic [37:0] sq_trial;
  logic [35:0] zprod;
  logic [34:0] nprod;
  logic [18:0] nround;
  logic [23:0] tprod, hprod;
  logic signed [11:0] temp_sum, hum_sum, temp_sat, hum_sat;
  logic [2:0]  band_nxt;

  assign rng_nxt = rng_r * LCG_MUL + LCG_INC;
  assign site_nxt = ((int'(in_site_index) < SITES) && (int'(in_site_index) < ROM_SITES))
                    ? in_site_index : 3'd0;
  assign cos_k = u2_r[28 -: COS_TABLE_BITS];
  assign cos_idx = u2_r[29] ? ((COS_TABLE_BITS + 1)'(COS_N) - {1'b0, cos_k})
                            : {1'b0, cos_k};
  assign lq = 21'(2 * (22'(e_r) * 22'(LN2_Q16) - 22'(log_q_r)));
  assign sq_trial = sq_res_r + sq_bit_r;
  assign zprod = 36'(sq_res_r[18:0]) * 36'(cos_q_r);
  assign nprod = 35'(z_r) * 35'(NOISE_GAIN_Q16);
  assign nround = 19'((nprod + 35'd32768) >> 16);
  assign tprod = 24'(n_r) * 24'(SPREAD_TEMP[site_r]) + 24'd32768;
  assign hprod = 24'(n_r) * 24'(SPREAD_HUM[site_r]) + 24'd32768;

  always_comb begin
    temp_sum = neg_r ? 12'(NOMINAL_TEMP[site_r]) - 12'(toff_r)
                     : 12'(NOMINAL_TEMP[site_r]) + 12'(toff_r);
    hum_sum = neg_r ? 12'(BASE_HUM[site_r]) - 12'(hoff_r)
                    : 12'(BASE_HUM[site_r]) + 12'(hoff_r);
    priority if (temp_sum < TEMP_MIN) begin
      temp_sat = TEMP_MIN;
    end else if (temp_sum > TEMP_MAX) begin
      temp_sat = TEMP_MAX;
    end else begin
      temp_sat = temp_sum;
    end
    priority if (hum_sum < 12'sd0) begin
      hum_sat = 12'sd0;
    end else if (hum_sum > HUM_MAX) begin
      hum_sat = HUM_MAX;
    end else begin
      hum_sat = hum_sum;
    end
    priority if (temp_sat < BAND_LIM0) begin
      band_nxt = 3'd0;
    end else if (temp_sat < BAND_LIM1) begin
      band_nxt = 3'd1;
    end else if (temp_sat < BAND_LIM2) begin
      band_nxt = 3'd2;
    end else if (temp_sat < BAND_LIM3) begin
      band_nxt = 3'd3;
    end else if (temp_sat < BAND_LIM4) begin
      band_nxt = 3'd4;
    end else begin
      band_nxt = 3'd5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        rng_r <= cfg_seed;
      end else if (cmd.draw1 || cmd.draw2) begin
        rng_r <= rng_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    log_q_r <= LOG_TAB[u1_r[29 -: LOG_TABLE_BITS]];
    cos_q_r <= COS_TAB[cos_idx];
    if (cmd.load_site) begin
      site_r <= site_nxt;
    end
    if (cmd.draw1) begin
      u1_r <= (rng_nxt[30:0] < U1_FLOOR) ? U1_FLOOR : rng_nxt[30:0];
      e_r <= 5'd1;
    end
    if (cmd.draw2) begin
      u2_r <= rng_nxt[30:0];
      neg_r <= rng_nxt[30] ^ rng_nxt[29];
    end
    if (cmd.norm_step) begin
      u1_r <= {u1_r[29:0], 1'b0};
      e_r <= e_r + 5'd1;
    end
    if (cmd.sq_init) begin
      sq_v_r <= {1'b0, lq, 16'd0};
      sq_res_r <= '0;
      sq_bit_r <= SQ_TOP_BIT;
    end
    if (cmd.sq_step) begin
      if (sq_v_r >= sq_trial) begin
        sq_v_r <= sq_v_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.mul_z) begin
      z_r <= 20'((zprod + 36'd32768) >> 16);
    end
    if (cmd.mul_n) begin
      n_r <= (nround > 19'(ONE_Q16)) ? ONE_Q16 : nround[16:0];
    end
    if (cmd.mul_off) begin
      toff_r <= tprod[22:16];
      hoff_r <= hprod[22:16];
    end
    if (cmd.load_out) begin
      temp_r <= temp_sat[10:0];
      hum_r <= hum_sat[9:0];
      band_r <= band_nxt;
      used_r <= site_r;
    end
  end

  assign status.norm_done = u1_r[30];
  assign status.sq_done = (sq_bit_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_temperature_tenths = temp_r;
  assign out_humidity_tenths = hum_r;
  assign out_comfort_band = band_r;
  assign out_site_used = used_r;

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (used_r < 3'd6 && hum_r <= 10'd1000 && band_r <= 3'd5))
    else $error("result outside its range");

  a_norm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm_step |-> (e_r < 5'd21))
    else $error("normalisation ran past the floor of u1");

endmodule

FILE: src/noisy_sensor_reading_generator.sv
// The time from an accepted request to its result is set by the leading-zero
// shift of u1 (0 to 19 shifts) and the 19-step square root.
// Requests: no new request is taken until the previous result is loaded;
// the next request is taken while the previous result waits in the output register.
// Reset: synchronous active-low; the generator state returns to seed 1.
module noisy_sensor_reading_generator #(
  parameter int SITES = 6,
  parameter int LOG_TABLE_BITS = 10,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic clk,
  input  logic rst_n,
  nsr_in_if.sink    in_ch,
  nsr_out_if.source out_ch,
  nsr_cfg_if.sink   cfg_ch
);
  import nsr_pkg::*;

  nsr_cmd_t    cmd;
  nsr_status_t status;

  assign cfg_ch.ready = 1'b1;

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nsr_datapath #(
    .SITES          (SITES),
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_site_index          (in_ch.site_index),
    .cfg_write              (cfg_ch.valid),
    .cfg_seed               (cfg_ch.noise_seed),
    .cmd                    (cmd),
    .status                 (status),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_temperature_tenths (out_ch.temperature_tenths),
    .out_humidity_tenths    (out_ch.humidity_tenths),
    .out_comfort_band       (out_ch.comfort_band),
    .out_site_used          (out_ch.site_used)
  );

endmodule
